FILE: design/cau_pkg.sv
// Shared types, constants and helpers for the complex arithmetic unit.
// Used by every module of the unit; depends on nothing else.
`timescale 1ns / 1ps
package cau_pkg;

    // Fixed point format and quotient width
    localparam int DATA_W        = 16;
    localparam int FRAC_BITS_DEF = 8;
    localparam int QUO_W         = 17;
    localparam int DEN_W         = 32;
    localparam int REM_W         = 49;

    // Operation codes
    localparam logic [1:0] MODE_ADD = 2'd0;
    localparam logic [1:0] MODE_SUB = 2'd1;
    localparam logic [1:0] MODE_MUL = 2'd2;
    localparam logic [1:0] MODE_DIV = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIVZ = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    localparam logic signed [DATA_W-1:0] Q_MAX = 16'sh7FFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 16'sh8000;

    // One lane of the long division: sign, overflow, remainder, quotient
    typedef struct packed {
        logic              neg;
        logic              ovf;
        logic [REM_W-1:0]  rem;
        logic [QUO_W-1:0]  quo;
    } t_lane;

    // Beat travelling down the row of division cells
    typedef struct packed {
        logic                     is_div;
        logic [1:0]               status;
        logic signed [DATA_W-1:0] byp_re;
        logic signed [DATA_W-1:0] byp_im;
        logic [DEN_W-1:0]         den;
        t_lane                    re;
        t_lane                    im;
    } t_div;

    typedef struct packed {
        logic                     sat;
        logic signed [DATA_W-1:0] val;
    } t_sat;

    // Clamp a 34-bit signed value to the 16-bit signed range
    function automatic t_sat sat34(input logic signed [33:0] v);
        t_sat r;
        r.sat = 1'b0;
        r.val = v[DATA_W-1:0];
        if (v > 34'sd32767) begin
            r.sat = 1'b1;
            r.val = Q_MAX;
        end else if (v < -34'sd32768) begin
            r.sat = 1'b1;
            r.val = Q_MIN;
        end
        return r;
    endfunction

    // Apply sign to a quotient magnitude and clamp it
    function automatic t_sat fix_quo(input t_lane l);
        t_sat r;
        logic signed [DATA_W-1:0] mag;
        mag   = l.quo[DATA_W-1:0];
        r.sat = 1'b0;
        r.val = l.neg ? -mag : mag;
        if (l.ovf || (l.neg ? (l.quo > 17'd32768) : (l.quo > 17'd32767))) begin
            r.sat = 1'b1;
            r.val = l.neg ? Q_MIN : Q_MAX;
        end
        return r;
    endfunction

endpackage

FILE: design/cau_front.sv
// Front end: cross products, then add/sub/mul results and division set-up.
// Depends on cau_pkg.
`timescale 1ns / 1ps
module cau_front #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [1:0]                       i_mode,
    input  logic signed [cau_pkg::DATA_W-1:0] i_a_re,
    input  logic signed [cau_pkg::DATA_W-1:0] i_a_im,
    input  logic signed [cau_pkg::DATA_W-1:0] i_b_re,
    input  logic signed [cau_pkg::DATA_W-1:0] i_b_im,
    output logic                             o_valid,
    input  logic                             i_ready,
    output cau_pkg::t_div                    o_data
);

    // Product stage registers
    logic                             r_va;
    logic [1:0]                       r_mode;
    logic signed [cau_pkg::DATA_W-1:0] r_ar, r_ai, r_br, r_bi;
    logic signed [31:0]               r_p_rr, r_p_ii, r_p_ri, r_p_ir, r_p_b1, r_p_b2;
    logic                             ready_a;

    // Set-up stage registers
    logic          r_vb;
    cau_pkg::t_div r_data;
    cau_pkg::t_div n_data;

    assign o_ready = !r_va || ready_a;
    assign ready_a = !r_vb || i_ready;

    // Product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (o_ready) begin
            r_va <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_mode <= i_mode;
            r_ar   <= i_a_re;
            r_ai   <= i_a_im;
            r_br   <= i_b_re;
            r_bi   <= i_b_im;
            r_p_rr <= i_a_re * i_b_re;
            r_p_ii <= i_a_im * i_b_im;
            r_p_ri <= i_a_re * i_b_im;
            r_p_ir <= i_a_im * i_b_re;
            r_p_b1 <= i_b_re * i_b_re;
            r_p_b2 <= i_b_im * i_b_im;
        end
    end

    // Add, subtract and multiply results, and numerators for the divider
    always_comb begin
        logic signed [33:0]         s_re, s_im, num_re, num_im;
        logic [32:0]                mag_re, mag_im;
        logic [cau_pkg::REM_W-1:0]  n_re, n_im, den_w;
        cau_pkg::t_sat              q_re, q_im;
        s_re   = '0;
        s_im   = '0;
        num_re = 34'(r_p_rr) + 34'(r_p_ii);
        num_im = 34'(r_p_ir) - 34'(r_p_ri);
        mag_re = num_re[33] ? 33'(-num_re) : num_re[32:0];
        mag_im = num_im[33] ? 33'(-num_im) : num_im[32:0];
        n_re   = cau_pkg::REM_W'(mag_re) << FRAC_BITS;
        n_im   = cau_pkg::REM_W'(mag_im) << FRAC_BITS;

        n_data.is_div = 1'b0;
        n_data.status = cau_pkg::ST_OK;
        n_data.den    = cau_pkg::DEN_W'(r_p_b1) + cau_pkg::DEN_W'(r_p_b2);
        den_w         = cau_pkg::REM_W'(n_data.den);

        case (r_mode)
            cau_pkg::MODE_ADD: begin
                s_re = 34'(r_ar) + 34'(r_br);
                s_im = 34'(r_ai) + 34'(r_bi);
            end
            cau_pkg::MODE_SUB: begin
                s_re = 34'(r_ar) - 34'(r_br);
                s_im = 34'(r_ai) - 34'(r_bi);
            end
            cau_pkg::MODE_MUL: begin
                s_re = (34'(r_p_rr) - 34'(r_p_ii)) >>> FRAC_BITS;
                s_im = (34'(r_p_ri) + 34'(r_p_ir)) >>> FRAC_BITS;
            end
            default: begin
                s_re = 34'(r_ar);
                s_im = 34'(r_ai);
            end
        endcase
        q_re = cau_pkg::sat34(s_re);
        q_im = cau_pkg::sat34(s_im);

        n_data.byp_re = q_re.val;
        n_data.byp_im = q_im.val;
        if (q_re.sat || q_im.sat) begin
            n_data.status = cau_pkg::ST_SAT;
        end
        if (r_mode == cau_pkg::MODE_DIV) begin
            if (n_data.den == '0) begin
                n_data.status = cau_pkg::ST_DIVZ;
            end else begin
                n_data.is_div = 1'b1;
            end
        end

        // A quotient of 2^17 or more is flagged before the division starts
        n_data.re.neg = num_re[33];
        n_data.re.ovf = (n_re >> cau_pkg::QUO_W) >= den_w;
        n_data.re.rem = n_re;
        n_data.re.quo = '0;
        n_data.im.neg = num_im[33];
        n_data.im.ovf = (n_im >> cau_pkg::QUO_W) >= den_w;
        n_data.im.rem = n_im;
        n_data.im.quo = '0;
    end

    // Set-up stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else if (ready_a) begin
            r_vb <= r_va;
        end
        if (ready_a && r_va) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_vb;
    assign o_data  = r_data;

endmodule

FILE: design/cau_cell.sv
// One restoring-division cell: settles one quotient bit for both lanes.
// Depends on cau_pkg.
`timescale 1ns / 1ps
module cau_cell #(
    parameter int STEP = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  cau_pkg::t_div i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output cau_pkg::t_div o_data
);

    logic          r_valid;
    cau_pkg::t_div r_data;
    cau_pkg::t_div n_data;

    assign o_ready = !r_valid || i_ready;

    // Subtract the divisor at this bit weight where it fits
    always_comb begin
        logic [cau_pkg::REM_W-1:0] dsh;
        dsh    = cau_pkg::REM_W'(i_data.den) << STEP;
        n_data = i_data;
        if (i_data.re.rem >= dsh) begin
            n_data.re.rem       = i_data.re.rem - dsh;
            n_data.re.quo[STEP] = 1'b1;
        end
        if (i_data.im.rem >= dsh) begin
            n_data.im.rem       = i_data.im.rem - dsh;
            n_data.im.quo[STEP] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: design/complex_arithmetic_unit.sv
// Top level of the complex arithmetic unit: front end, division cells, output.
// Depends on cau_pkg, cau_front and cau_cell.
//
// Usage:
//   Input channel i_valid/o_ready carries one beat: mode plus two complex
//   operands in signed Q8.8. Output channel o_valid/i_ready carries the
//   result parts and a status (ok, divide by zero, saturated).
//   Every mode takes the same path from input beat to output beat:
//   two front-end stages, one cell per quotient bit (17 cells) and the
//   output register. Add, subtract and multiply ride through the cells
//   unchanged so that results leave in order.
//   Throughput is one beat per cycle while the receiver does not stall;
//   the rate is set by the row of cells, each taking one beat per cycle.
//   Every stage holds its own valid bit, so a stalled receiver fills the
//   pipeline from the output end and bubbles are squeezed out; o_ready
//   drops only when all 20 stages hold a beat.
//   Reset clears all valid bits; no clearing pass is needed.
`timescale 1ns / 1ps
module complex_arithmetic_unit #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [1:0]                       i_mode,
    input  logic signed [cau_pkg::DATA_W-1:0] i_a_re,
    input  logic signed [cau_pkg::DATA_W-1:0] i_a_im,
    input  logic signed [cau_pkg::DATA_W-1:0] i_b_re,
    input  logic signed [cau_pkg::DATA_W-1:0] i_b_im,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic signed [cau_pkg::DATA_W-1:0] o_res_re,
    output logic signed [cau_pkg::DATA_W-1:0] o_res_im,
    output logic [1:0]                       o_status
);

    localparam int NCELL = cau_pkg::QUO_W;

    logic          c_valid [NCELL+1];
    logic          c_ready [NCELL+1];
    cau_pkg::t_div c_data  [NCELL+1];

    logic                              r_valid;
    logic signed [cau_pkg::DATA_W-1:0] r_re, r_im;
    logic [1:0]                        r_status;
    logic                              out_ready;

    cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_mode  (i_mode),
        .i_a_re  (i_a_re),
        .i_a_im  (i_a_im),
        .i_b_re  (i_b_re),
        .i_b_im  (i_b_im),
        .o_valid (c_valid[0]),
        .i_ready (c_ready[0]),
        .o_data  (c_data[0])
    );

    // Row of cells, most significant quotient bit first
    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        cau_cell #(.STEP(NCELL-1-g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[g]),
            .o_ready (c_ready[g]),
            .i_data  (c_data[g]),
            .o_valid (c_valid[g+1]),
            .i_ready (c_ready[g+1]),
            .o_data  (c_data[g+1])
        );
    end

    assign out_ready      = !r_valid || i_ready;
    assign c_ready[NCELL] = out_ready;

    // Output register: sign and clamp the quotients or pass the bypass result
    always_ff @(posedge i_clk) begin
        cau_pkg::t_sat q_re, q_im;
        q_re = cau_pkg::fix_quo(c_data[NCELL].re);
        q_im = cau_pkg::fix_quo(c_data[NCELL].im);
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (out_ready) begin
            r_valid <= c_valid[NCELL];
        end
        if (out_ready && c_valid[NCELL]) begin
            if (c_data[NCELL].is_div) begin
                r_re     <= q_re.val;
                r_im     <= q_im.val;
                r_status <= (q_re.sat || q_im.sat) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
            end else begin
                r_re     <= c_data[NCELL].byp_re;
                r_im     <= c_data[NCELL].byp_im;
                r_status <= c_data[NCELL].status;
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_res_re = r_re;
    assign o_res_im = r_im;
    assign o_status = r_status;

endmodule

FILE: design/cau_checker.sv
// Port-level checks for the complex arithmetic unit, bound to the top level.
// Depends on cau_pkg and complex_arithmetic_unit.
`timescale 1ns / 1ps
module cau_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_valid,
    input logic                             i_ready,
    input logic signed [cau_pkg::DATA_W-1:0] o_res_re,
    input logic signed [cau_pkg::DATA_W-1:0] o_res_im,
    input logic [1:0]                       o_status
);

    // A stalled result beat stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_res_re) && $stable(o_res_im)))
        else $error("result beat dropped or changed while stalled");

    // Nothing leaves straight after reset
    a_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result beat shown right after reset");

    // Only defined status codes appear
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == cau_pkg::ST_OK || o_status == cau_pkg::ST_DIVZ ||
                     o_status == cau_pkg::ST_SAT))
        else $error("undefined status code");

    // A saturated result has at least one part at a range limit
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == cau_pkg::ST_SAT) |->
            (o_res_re == cau_pkg::Q_MAX || o_res_re == cau_pkg::Q_MIN ||
             o_res_im == cau_pkg::Q_MAX || o_res_im == cau_pkg::Q_MIN))
        else $error("saturation flagged without a clamped part");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_valid  (o_valid),
    .i_ready  (i_ready),
    .o_res_re (o_res_re),
    .o_res_im (o_res_im),
    .o_status (o_status)
);

FILE: dv/complex_arithmetic_unit_tb.sv
// Self-checking testbench for the complex arithmetic unit.
// Depends on cau_pkg and complex_arithmetic_unit; predicts every result in a scoreboard class.
`timescale 1ns / 1ps
module complex_arithmetic_unit_tb;

    localparam int LATENCY     = 20;
    localparam int STALL_LIMIT = 5000;
    localparam int N_RANDOM    = 1900;

    typedef struct {
        logic signed [15:0] re;
        logic signed [15:0] im;
        logic [1:0]         status;
    } t_cplx_res;

    // Scoreboard: predicts each result and checks the results in order.
    class cplx_scoreboard;
        t_cplx_res pending_q[$];
        int        n_errors;

        function automatic longint clamp16(input longint v, inout bit sat);
            if (v > 32767) begin
                sat = 1;
                return 32767;
            end
            if (v < -32768) begin
                sat = 1;
                return -32768;
            end
            return v;
        endfunction

        // Floor division by 2^8.
        function automatic longint floor_q8(input longint v);
            if (v >= 0) return v / 256;
            return -((-v + 255) / 256);
        endfunction

        function void note_operands(input logic [1:0] mode, input logic signed [15:0] ar,
                                    input logic signed [15:0] ai, input logic signed [15:0] br,
                                    input logic signed [15:0] bi);
            t_cplx_res r;
            longint    xr, xi, yr, yi, den, rr, ri;
            bit        sat;
            xr = ar; xi = ai; yr = br; yi = bi;
            sat = 0;
            r.status = cau_pkg::ST_OK;
            case (mode)
                cau_pkg::MODE_ADD: begin
                    rr = clamp16(xr + yr, sat);
                    ri = clamp16(xi + yi, sat);
                end
                cau_pkg::MODE_SUB: begin
                    rr = clamp16(xr - yr, sat);
                    ri = clamp16(xi - yi, sat);
                end
                cau_pkg::MODE_MUL: begin
                    rr = clamp16(floor_q8(xr * yr - xi * yi), sat);
                    ri = clamp16(floor_q8(xr * yi + xi * yr), sat);
                end
                default: begin
                    den = yr * yr + yi * yi;
                    if (den == 0) begin
                        rr = xr;
                        ri = xi;
                        r.status = cau_pkg::ST_DIVZ;
                    end else begin
                        rr = clamp16(((xr * yr + xi * yi) * 256) / den, sat);
                        ri = clamp16(((xi * yr - xr * yi) * 256) / den, sat);
                    end
                end
            endcase
            if (sat) r.status = cau_pkg::ST_SAT;
            r.re = rr[15:0];
            r.im = ri[15:0];
            pending_q.push_back(r);
        endfunction

        function void check_result(input logic signed [15:0] re, input logic signed [15:0] im,
                                   input logic [1:0] status);
            t_cplx_res e;
            if (pending_q.size() == 0) begin
                $error("result beat with nothing expected");
                n_errors++;
                return;
            end
            e = pending_q.pop_front();
            if (re !== e.re) begin
                $error("res_re expected %0d actual %0d", e.re, re);
                n_errors++;
            end
            if (im !== e.im) begin
                $error("res_im expected %0d actual %0d", e.im, im);
                n_errors++;
            end
            if (status !== e.status) begin
                $error("status expected %0d actual %0d", e.status, status);
                n_errors++;
            end
        endfunction
    endclass

    logic               i_clk, i_rst_n, i_valid, o_ready, o_valid, i_ready;
    logic [1:0]         i_mode, o_status;
    logic signed [15:0] i_a_re, i_a_im, i_b_re, i_b_im, o_res_re, o_res_im;

    cplx_scoreboard sb;
    bit             quiet_phase;   // no idling on either side
    bit             hold_off;      // receiver holds off for a long stretch
    bit             stim_done;
    int             idle_cycles;

    complex_arithmetic_unit dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Note every accepted input beat and check every accepted result beat.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) sb.note_operands(i_mode, i_a_re, i_a_im, i_b_re, i_b_im);
            if (o_valid && i_ready) sb.check_result(o_res_re, o_res_im, o_status);
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    // Watchdog on cycles without any beat.
    always @(posedge i_clk) begin
        if (idle_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_off) i_ready <= 1'b0;
        else if (quiet_phase) i_ready <= 1'b1;
        else i_ready <= ($urandom_range(99) >= 31);
    end

    initial begin
        hold_off = 0;
        wait (i_rst_n === 1'b1);
        repeat (300) @(posedge i_clk);
        hold_off = 1;
        repeat (200) @(posedge i_clk);
        hold_off = 0;
    end

    function automatic logic signed [15:0] pick_value();
        case ($urandom_range(9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return 16'($urandom_range(1023) - 512);
            4: return 16'($urandom_range(255) * 256 - 32768);
            default: return 16'($urandom());
        endcase
    endfunction

    // Offer one beat and hold it until it is accepted; idle first at random.
    task automatic send_beat(input logic [1:0] mode, input logic signed [15:0] ar,
                             input logic signed [15:0] ai, input logic signed [15:0] br,
                             input logic signed [15:0] bi);
        while (!quiet_phase && $urandom_range(99) < 31) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode  <= mode;
        i_a_re  <= ar;
        i_a_im  <= ai;
        i_b_re  <= br;
        i_b_im  <= bi;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    initial begin
        logic signed [15:0] ext[4];
        logic signed [15:0] br, bi;
        int                 wait_cycles;
        sb = new();
        quiet_phase = 0;
        stim_done = 0;
        idle_cycles = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_mode = cau_pkg::MODE_ADD;
        i_a_re = '0; i_a_im = '0; i_b_re = '0; i_b_im = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: field extremes in every mode, zero divisor, saturation.
        ext = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0100};
        for (int m = 0; m < 4; m++) begin
            send_beat(m[1:0], ext[0], ext[1], ext[0], ext[0]);
            send_beat(m[1:0], ext[1], ext[1], ext[1], ext[1]);
            send_beat(m[1:0], ext[3], ext[0], ext[3], ext[1]);
            send_beat(m[1:0], ext[1], ext[0], ext[2], ext[2]);
        end
        send_beat(cau_pkg::MODE_DIV, 16'sh0200, 16'shFF00, 16'sh0001, 16'sh0000);
        send_beat(cau_pkg::MODE_DIV, 16'sh0300, 16'sh0100, 16'sh0100, 16'sh0100);
        send_beat(cau_pkg::MODE_MUL, 16'shFF80, 16'sh0001, 16'sh0001, 16'sh0001);

        // Random part, with a stretch that has no idling at all.
        for (int n = 0; n < N_RANDOM; n++) begin
            quiet_phase = (n >= 600 && n < 900);
            br = pick_value();
            bi = pick_value();
            if ($urandom_range(19) == 0) begin
                br = '0;
                bi = '0;
            end
            send_beat(2'($urandom_range(3)), pick_value(), pick_value(), br, bi);
        end
        i_valid <= 1'b0;
        quiet_phase = 0;
        stim_done = 1;

        wait_cycles = 0;
        while (sb.pending_q.size() > 0 && wait_cycles < 100000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (LATENCY + 5) @(posedge i_clk);
        if (sb.n_errors == 0 && sb.pending_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
